// ===== hdl/sgd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgd_pkg: shared types and constants for the Sobel gradient/direction core
// Holds the image size limits, field widths, register indexes, the queue
// entry that carries one full 3x3 window and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package sgd_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;

   localparam int PIX_W   = 8;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int WIDTH_W = COL_W + 1;
   localparam int HEIGHT_W = ROW_W + 1;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

   // result packing
   localparam int MAG_W       = 8;
   localparam int DIR_W       = 3;
   localparam int RSP_FIELD_W = MAG_W + DIR_W + COL_W + ROW_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   // tan(22.5 deg) in Q16
   localparam logic [14:0] TAN22_Q16 = 15'd27146;

   // direction sectors
   localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd0;
   localparam logic [DIR_W-1:0] DIR_RIGHT_DOWN = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN       = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT_DOWN  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd4;
   localparam logic [DIR_W-1:0] DIR_LEFT_UP    = 3'd5;
   localparam logic [DIR_W-1:0] DIR_UP         = 3'd6;
   localparam logic [DIR_W-1:0] DIR_RIGHT_UP   = 3'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int ROOT_STEPS  = 8;
   localparam int STEP_W      = $clog2(ROOT_STEPS);

   // one full window plus the position of its center
   typedef struct packed {
      logic [8:0][PIX_W-1:0] win;   // row-major, index 0 = top left
      logic [COL_W-1:0]      col;
      logic [ROW_W-1:0]      row;
      logic                  last;
   } win_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MULT,
      BK_ROOT,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

// ===== hdl/sobel_gradient_direction_core.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_direction_core: streaming 3x3 Sobel edge detector
// Grey pixels in, gradient magnitude and 45-degree direction sector out.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order on the req_ stream, one item per pixel. The
// front end takes one pixel per clock while no window waits on a full queue,
// keeps the two previous lines in a single dual-byte line store and slides
// a 3x3 window; a pixel in column 0 or 1 or in row 0 or 1 completes no
// window and gives no result. Every full window goes through a four-entry
// queue to the back end, which forms the Sobel sums (each divided by 4
// toward zero), then the squares and tangent products, then the bit-pair
// square root, and last hands the result to the output register; it takes
// a new window only once the last result is in the output register. Border
// pixels pass at one per clock until the queue fills. Magnitude saturates
// at 255; direction 0 is right, 2 is down, 4 is left, 6 is up, and a zero
// gradient reads as 0. rsp_tlast marks the result of the last pixel of a
// frame. Writing image_width (index 0) or image_height (index 1) clamps the
// value to 3..1024 or 3..4096 and restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_gradient_direction_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // configuration
   input  wire logic                               csr_we,
   input  wire logic [sgd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sgd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // pixel stream
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [sgd_pkg::PIX_W-1:0]          req_tdata,  // [7:0] pixel
   // result stream
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [7:0] magnitude, [10:8] direction, [20:11] center_col,
   // [32:21] center_row, [39:33] zero
   output logic [sgd_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tlast   // frame_last
);
   import sgd_pkg::*;

   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   win_entry_type q_wdata;
   win_entry_type q_rdata;

   // intake, line store and window
   sgd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (q_push),
      .q_wdata    (q_wdata),
      .q_full     (q_full)
   );

   // decouple window intake from the slow arithmetic
   sgd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .valid (q_valid)
   );

   // gradient, root and sector, plus output register
   sgd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rdata    (q_rdata),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hdl/sgd_front.sv =====
// ----------------------------------------------------------------------------
// sgd_front: pixel intake, line store and 3x3 window
// Tracks the raster position, reads and rewrites the line store, slides the
// window and pushes every full window into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [sgd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [sgd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [sgd_pkg::PIX_W-1:0]          req_tdata,
   output logic                                    q_push,
   output sgd_pkg::win_entry_type                  q_wdata,
   input  wire logic                               q_full
);
   import sgd_pkg::*;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [WIDTH_W-1:0]  width_in;
   logic [HEIGHT_W-1:0] height_in;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                col_end;
   logic                row_end;
   logic                accept;

   // stage 1: line store data is back
   logic                s1_valid_ff;
   logic [PIX_W-1:0]    s1_pix_ff;
   logic [COL_W-1:0]    s1_col_ff;
   logic [COL_W-1:0]    s1_ccol_ff;
   logic [ROW_W-1:0]    s1_crow_ff;
   logic                s1_prod_ff;
   logic                s1_last_ff;
   logic                s1_adv;

   // older line in the upper byte, newer line in the lower byte
   logic [2*PIX_W-1:0]  line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0]  rd_ff;
   logic [PIX_W-1:0]    top;
   logic [PIX_W-1:0]    mid;

   logic [8:0][PIX_W-1:0] win_ff;
   logic [8:0][PIX_W-1:0] win_in;

   always_comb begin
      width_in = csr_wdata[WIDTH_W-1:0];
      if (width_in < WIDTH_MIN) begin
         width_in = WIDTH_MIN;
      end else if (width_in > WIDTH_MAX) begin
         width_in = WIDTH_MAX;
      end
      height_in = csr_wdata[HEIGHT_W-1:0];
      if (height_in < HEIGHT_MIN) begin
         height_in = HEIGHT_MIN;
      end else if (height_in > HEIGHT_MAX) begin
         height_in = HEIGHT_MAX;
      end
   end

   assign col_end    = ({1'b0, col_ff} == width_ff - WIDTH_W'(1));
   assign row_end    = ({1'b0, row_ff} == height_ff - HEIGHT_W'(1));
   assign s1_adv     = s1_valid_ff && (!s1_prod_ff || !q_full);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we && (csr_index == REG_IMAGE_WIDTH)) begin
         width_ff <= width_in;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (csr_we && (csr_index == REG_IMAGE_HEIGHT)) begin
         height_ff <= height_in;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (accept) begin
         if (col_end) begin
            col_ff <= '0;
            row_ff <= row_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_tdata;
         s1_col_ff  <= col_ff;
         s1_ccol_ff <= col_ff - COL_W'(1);
         s1_crow_ff <= row_ff - ROW_W'(1);
         s1_prod_ff <= (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
         s1_last_ff <= col_end && row_end;
      end
   end

   // line store: read on intake, write back the shifted pair when stage 1 advances
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_col_ff] <= {rd_ff[PIX_W-1:0], s1_pix_ff};
      end
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   assign top = rd_ff[2*PIX_W-1:PIX_W];
   assign mid = rd_ff[PIX_W-1:0];

   always_comb begin
      win_in[0] = win_ff[1];
      win_in[1] = win_ff[2];
      win_in[2] = top;
      win_in[3] = win_ff[4];
      win_in[4] = win_ff[5];
      win_in[5] = mid;
      win_in[6] = win_ff[7];
      win_in[7] = win_ff[8];
      win_in[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff <= win_in;
      end
   end

   assign q_push       = s1_adv && s1_prod_ff;
   assign q_wdata.win  = win_in;
   assign q_wdata.col  = s1_ccol_ff;
   assign q_wdata.row  = s1_crow_ff;
   assign q_wdata.last = s1_last_ff;

endmodule

`default_nettype wire

// ===== hdl/sgd_queue.sv =====
// ----------------------------------------------------------------------------
// sgd_queue: short window queue between front and back
// Register-based FIFO; head entry is visible while valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire sgd_pkg::win_entry_type  wdata,
   output logic                         full,
   input  wire logic                    pop,
   output sgd_pkg::win_entry_type       rdata,
   output logic                         valid
);
   import sgd_pkg::*;

   win_entry_type       store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && valid;
   assign rdata   = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/sgd_back.sv =====
// ----------------------------------------------------------------------------
// sgd_back: gradient, magnitude and direction for one window
// Forms the Sobel sums, squares them, takes an iterative floor square root
// and picks the angle sector, then holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgd_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sgd_pkg::win_entry_type             q_rdata,
   input  wire logic                               q_valid,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [sgd_pkg::RSP_TDATA_W-1:0]         rsp_tdata,
   output logic                                    rsp_tlast
);
   import sgd_pkg::*;

   back_state_type      state_ff;
   back_state_type      state_in;

   logic signed [10:0]  gx_raw;
   logic signed [10:0]  gy_raw;
   logic signed [10:0]  gx_div;
   logic signed [10:0]  gy_div;
   logic [9:0]          sum_pos_x;
   logic [9:0]          sum_neg_x;
   logic [9:0]          sum_pos_y;
   logic [9:0]          sum_neg_y;

   logic signed [8:0]   gx_ff;
   logic signed [8:0]   gy_ff;
   logic [8:0]          ax_full;
   logic [8:0]          ay_full;
   logic [7:0]          ax;
   logic [7:0]          ay;
   logic [15:0]         sqx;
   logic [15:0]         sqy;
   logic [16:0]         sq_ff;
   logic [22:0]         tx_ff;
   logic [22:0]         ty_ff;

   logic [16:0]         rem_ff;
   logic [16:0]         root_ff;
   logic [16:0]         bit_ff;
   logic [16:0]         trial;
   logic [STEP_W-1:0]   step_ff;
   logic [DIR_W-1:0]    dir_ff;
   logic [DIR_W-1:0]    dir_in;

   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic                last_ff;

   logic                out_load;
   logic                rsp_valid_ff;
   logic [MAG_W-1:0]    rsp_mag_ff;
   logic [DIR_W-1:0]    rsp_dir_ff;
   logic [COL_W-1:0]    rsp_col_ff;
   logic [ROW_W-1:0]    rsp_row_ff;
   logic                rsp_last_ff;

   // Sobel sums on the queue head
   always_comb begin
      sum_pos_x = {2'b0, q_rdata.win[2]} + {1'b0, q_rdata.win[5], 1'b0}
                  + {2'b0, q_rdata.win[8]};
      sum_neg_x = {2'b0, q_rdata.win[0]} + {1'b0, q_rdata.win[3], 1'b0}
                  + {2'b0, q_rdata.win[6]};
      sum_pos_y = {2'b0, q_rdata.win[6]} + {1'b0, q_rdata.win[7], 1'b0}
                  + {2'b0, q_rdata.win[8]};
      sum_neg_y = {2'b0, q_rdata.win[0]} + {1'b0, q_rdata.win[1], 1'b0}
                  + {2'b0, q_rdata.win[2]};
      gx_raw = $signed({1'b0, sum_pos_x}) - $signed({1'b0, sum_neg_x});
      gy_raw = $signed({1'b0, sum_pos_y}) - $signed({1'b0, sum_neg_y});
      // divide by four, truncating toward zero
      gx_div = gx_raw[10] ? ((gx_raw + 11'sd3) >>> 2) : (gx_raw >>> 2);
      gy_div = gy_raw[10] ? ((gy_raw + 11'sd3) >>> 2) : (gy_raw >>> 2);
   end

   assign ax_full = gx_ff[8] ? 9'(-gx_ff) : 9'(gx_ff);
   assign ay_full = gy_ff[8] ? 9'(-gy_ff) : 9'(gy_ff);
   assign ax      = ax_full[7:0];
   assign ay      = ay_full[7:0];
   assign sqx     = 16'(ax * ax);
   assign sqy     = 16'(ay * ay);
   assign trial   = root_ff + bit_ff;

   // sector from the exact Q16 tangent tests
   always_comb begin
      priority if ((ax == '0) && (ay == '0)) begin
         dir_in = DIR_RIGHT;
      end else if ({ay, 16'b0} < {1'b0, tx_ff}) begin
         dir_in = (gx_ff > 9'sd0) ? DIR_RIGHT : DIR_LEFT;
      end else if ({ax, 16'b0} < {1'b0, ty_ff}) begin
         dir_in = (gy_ff > 9'sd0) ? DIR_DOWN : DIR_UP;
      end else if (gx_ff > 9'sd0) begin
         dir_in = (gy_ff > 9'sd0) ? DIR_RIGHT_DOWN : DIR_RIGHT_UP;
      end else begin
         dir_in = (gy_ff > 9'sd0) ? DIR_LEFT_DOWN : DIR_LEFT_UP;
      end
   end

   assign out_load = (state_ff == BK_DONE) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = BK_MULT;
            end
         end
         BK_MULT: begin
            state_in = BK_ROOT;
         end
         BK_ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BK_IDLE: begin
            gx_ff   <= gx_div[8:0];
            gy_ff   <= gy_div[8:0];
            col_ff  <= q_rdata.col;
            row_ff  <= q_rdata.row;
            last_ff <= q_rdata.last;
         end
         BK_MULT: begin
            sq_ff   <= {1'b0, sqx} + {1'b0, sqy};
            rem_ff  <= {1'b0, sqx} + {1'b0, sqy};
            tx_ff   <= 23'(TAN22_Q16 * ax);
            ty_ff   <= 23'(TAN22_Q16 * ay);
            root_ff <= '0;
            bit_ff  <= 17'h04000;
            step_ff <= '0;
         end
         BK_ROOT: begin
            if (step_ff == '0) begin
               dir_ff <= dir_in;
            end
            if (rem_ff >= trial) begin
               rem_ff  <= rem_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            step_ff <= step_ff + STEP_W'(1);
         end
         BK_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_mag_ff  <= sq_ff[16] ? 8'hFF : root_ff[MAG_W-1:0];
         rsp_dir_ff  <= dir_ff;
         rsp_col_ff  <= col_ff;
         rsp_row_ff  <= row_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_FIELD_W)'(0),
                        rsp_row_ff, rsp_col_ff, rsp_dir_ff, rsp_mag_ff};

endmodule

`default_nettype wire
